FILE: src/ffa_pkg.sv
// Shared types, codes and defaults of the first-fit allocator.
`timescale 1ns / 1ps

package ffa_pkg;

    // Default sizing of the heap and of the two tables
    localparam int HEAP_BYTES_DEF      = 1024;
    localparam int HEADER_BYTES_DEF    = 16;
    localparam int MAX_EXTENTS_DEF     = 16;
    localparam int MAX_LIVE_BLOCKS_DEF = 16;

    // Fixed field widths of the request and response channels
    localparam int ADDR_W   = 10;
    localparam int SIZE_W   = 10;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFIT   = 2'd1;
    localparam t_status ST_UNKNOWN = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    typedef logic t_cmd;
    localparam t_cmd CMD_ALLOC = 1'b0;
    localparam t_cmd CMD_FREE  = 1'b1;

    // Update applied by the extent cells
    typedef logic [1:0] t_ext_op;
    localparam t_ext_op EXT_NONE   = 2'd0;
    localparam t_ext_op EXT_SHRINK = 2'd1;
    localparam t_ext_op EXT_REMOVE = 2'd2;
    localparam t_ext_op EXT_INSERT = 2'd3;

    // Update applied by the live-block cells
    typedef logic [1:0] t_live_op;
    localparam t_live_op LIVE_NONE  = 2'd0;
    localparam t_live_op LIVE_WRITE = 2'd1;
    localparam t_live_op LIVE_CLEAR = 2'd2;

    // Broadcast control to the extent row
    typedef struct packed {
        logic              match;
        t_ext_op           op;
        logic [SIZE_W-1:0] size;
    } t_ext_ctl;

    // Broadcast control to the live-block row
    typedef struct packed {
        logic              match;
        t_live_op          op;
        logic [ADDR_W-1:0] addr;
    } t_live_ctl;

endpackage

FILE: src/ffa_if.sv
// Request and response channel interfaces of the first-fit allocator.
`timescale 1ns / 1ps

interface ffa_req_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, command, request_size, block_address, input ready);
    modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [ADDR_W-1:0] granted_address;

    modport source (output valid, status, granted_address, input ready);
    modport sink   (input valid, status, granted_address, output ready);
endinterface

FILE: src/first_fit_free_list_allocator.sv
// Top level of the first-fit allocator: sequencer over the extent and live-block cell rows.
//
//   channel  dir  fields                                     transfer when
//   i_req    in   command, request_size, block_address       valid && ready
//   o_rsp    out  status, granted_address                    valid && ready
//
// A request passes through match (every cell compares in parallel), select
// (first-fit / first-free / first-hit priority ripples along the cell rows),
// apply (cells shift, shrink, write or clear), then the result sits in the output register.
// A new request is taken the cycle after the result is loaded.
// Reset is synchronous: one extent covers the heap after one header and all live
// valid bits clear; no clearing pass.
// A stalled response holds the block in the apply step until the register frees.
`timescale 1ns / 1ps

module first_fit_free_list_allocator #(
    parameter int HEAP_BYTES      = ffa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
    parameter int MAX_EXTENTS     = ffa_pkg::MAX_EXTENTS_DEF,
    parameter int MAX_LIVE_BLOCKS = ffa_pkg::MAX_LIVE_BLOCKS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    import ffa_pkg::*;

    localparam int LEN_W = $clog2(HEAP_BYTES + 1);
    localparam int GW    = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;
    localparam int CW    = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 2;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_SELECT = 2'd2;
    localparam logic [1:0] S_APPLY  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic              accept;
    logic              can_load;
    logic              do_apply;

    logic              r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    t_status           r_status;
    logic              r_big;
    logic [LEN_W-1:0]  r_grant;
    logic [LEN_W-1:0]  r_wr_len;
    logic [LEN_W-1:0]  r_blk_start;
    logic [LEN_W-1:0]  r_blk_len;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_grant;

    t_ext_ctl          ext_ctl;
    t_live_ctl         live_ctl;
    t_status           sel_status;
    logic [CW-1:0]     grant_calc;
    logic [GW-1:0]     grant_x;

    // Extent row wiring; padded arrays give cell i its neighbors at i and i+2
    logic [MAX_EXTENTS:0]   fit_chain;
    logic [MAX_EXTENTS:0]   le_chain;
    logic [LEN_W-1:0]       pad_start [MAX_EXTENTS+2];
    logic [LEN_W-1:0]       pad_len   [MAX_EXTENTS+2];
    logic [MAX_EXTENTS+1:0] pad_valid;
    logic [LEN_W-1:0]       ext_sel_start [MAX_EXTENTS];
    logic [LEN_W-1:0]       ext_sel_len   [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] ext_sel_big;
    logic [LEN_W-1:0]       ext_pick_start;
    logic [LEN_W-1:0]       ext_pick_len;
    logic                   ext_pick_big;

    // Live row wiring
    logic [MAX_LIVE_BLOCKS:0] hit_chain;
    logic [MAX_LIVE_BLOCKS:0] free_chain;
    logic [LEN_W-1:0]         live_sel_start [MAX_LIVE_BLOCKS];
    logic [LEN_W-1:0]         live_sel_len   [MAX_LIVE_BLOCKS];
    logic [LEN_W-1:0]         live_pick_start;
    logic [LEN_W-1:0]         live_pick_len;

    // Handshake
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign can_load    = !r_out_valid || o_rsp.ready;
    assign do_apply    = (r_state == S_APPLY) && can_load;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_MATCH;
            S_MATCH:  n_state = S_SELECT;
            S_SELECT: n_state = S_APPLY;
            S_APPLY:  if (can_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_req.command;
            r_size <= i_req.request_size;
            r_addr <= i_req.block_address;
        end
    end

    // Broadcast control to both rows
    always_comb begin
        ext_ctl.match   = (r_state == S_MATCH);
        ext_ctl.size    = r_size;
        ext_ctl.op      = EXT_NONE;
        live_ctl.match  = (r_state == S_MATCH);
        live_ctl.addr   = r_addr;
        live_ctl.op     = LIVE_NONE;
        if (do_apply && (r_status == ST_OK)) begin
            if (r_cmd == CMD_ALLOC) begin
                ext_ctl.op  = r_big ? EXT_SHRINK : EXT_REMOVE;
                live_ctl.op = LIVE_WRITE;
            end else begin
                ext_ctl.op  = EXT_INSERT;
                live_ctl.op = LIVE_CLEAR;
            end
        end
    end

    assign fit_chain[0]           = 1'b0;
    assign le_chain[0]            = 1'b1;
    assign pad_start[0]           = '0;
    assign pad_len[0]             = '0;
    assign pad_valid[0]           = 1'b0;
    assign pad_start[MAX_EXTENTS+1] = '0;
    assign pad_len[MAX_EXTENTS+1]   = '0;
    assign pad_valid[MAX_EXTENTS+1] = 1'b0;

    // Extent cell row
    for (genvar gi = 0; gi < MAX_EXTENTS; gi++) begin : g_ext
        ffa_extent_cell #(
            .LEN_W        (LEN_W),
            .HEADER_BYTES (HEADER_BYTES),
            .INIT_START   ((gi == 0) ? HEADER_BYTES : 0),
            .INIT_LEN     ((gi == 0) ? (HEAP_BYTES - HEADER_BYTES) : 0),
            .INIT_VALID   (gi == 0)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ext_ctl),
            .i_blk_start    (r_blk_start),
            .i_blk_len      (r_blk_len),
            .i_prev_fit_any (fit_chain[gi]),
            .o_fit_any      (fit_chain[gi+1]),
            .i_prev_le      (le_chain[gi]),
            .o_le           (le_chain[gi+1]),
            .i_prev_start   (pad_start[gi]),
            .i_prev_len     (pad_len[gi]),
            .i_prev_valid   (pad_valid[gi]),
            .i_next_start   (pad_start[gi+2]),
            .i_next_len     (pad_len[gi+2]),
            .i_next_valid   (pad_valid[gi+2]),
            .o_start        (pad_start[gi+1]),
            .o_len          (pad_len[gi+1]),
            .o_valid        (pad_valid[gi+1]),
            .o_sel_start    (ext_sel_start[gi]),
            .o_sel_len      (ext_sel_len[gi]),
            .o_sel_big      (ext_sel_big[gi])
        );
    end

    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;

    // Live-block cell row
    for (genvar gj = 0; gj < MAX_LIVE_BLOCKS; gj++) begin : g_live
        ffa_live_cell #(
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (live_ctl),
            .i_wr_start      (r_grant),
            .i_wr_len        (r_wr_len),
            .i_prev_hit_any  (hit_chain[gj]),
            .o_hit_any       (hit_chain[gj+1]),
            .i_prev_free_any (free_chain[gj]),
            .o_free_any      (free_chain[gj+1]),
            .o_sel_start     (live_sel_start[gj]),
            .o_sel_len       (live_sel_len[gj])
        );
    end

    // Gather the one selected extent and the one matching live block
    always_comb begin
        ext_pick_start = '0;
        ext_pick_len   = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            ext_pick_start = ext_pick_start | ext_sel_start[i];
            ext_pick_len   = ext_pick_len | ext_sel_len[i];
        end
        ext_pick_big = |ext_sel_big;
    end

    always_comb begin
        live_pick_start = '0;
        live_pick_len   = '0;
        for (int i = 0; i < MAX_LIVE_BLOCKS; i++) begin
            live_pick_start = live_pick_start | live_sel_start[i];
            live_pick_len   = live_pick_len | live_sel_len[i];
        end
    end

    // Outcome of the request
    always_comb begin
        if (r_cmd == CMD_ALLOC) begin
            if ((r_size == '0) || !fit_chain[MAX_EXTENTS]) begin
                sel_status = ST_NOFIT;
            end else if (!free_chain[MAX_LIVE_BLOCKS]) begin
                sel_status = ST_FULL;
            end else begin
                sel_status = ST_OK;
            end
        end else begin
            if (!hit_chain[MAX_LIVE_BLOCKS]) begin
                sel_status = ST_UNKNOWN;
            end else if (pad_valid[MAX_EXTENTS]) begin
                sel_status = ST_FULL;
            end else begin
                sel_status = ST_OK;
            end
        end
    end

    // Carved block sits at the top end of a large extent
    assign grant_calc = ext_pick_big ?
                        (CW'(ext_pick_start) + CW'(ext_pick_len) - CW'(r_size)) :
                        CW'(ext_pick_start);

    always_ff @(posedge i_clk) begin
        if (r_state == S_SELECT) begin
            r_status    <= sel_status;
            r_big       <= ext_pick_big;
            r_grant     <= LEN_W'(grant_calc);
            r_wr_len    <= ext_pick_big ? LEN_W'(r_size) : ext_pick_len;
            r_blk_start <= live_pick_start;
            r_blk_len   <= live_pick_len;
        end
    end

    // Output register
    assign grant_x = GW'(r_grant);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_apply) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_apply) begin
            r_out_status <= r_status;
            if ((r_cmd == CMD_ALLOC) && (r_status == ST_OK)) begin
                r_out_grant <= grant_x[ADDR_W-1:0];
            end else begin
                r_out_grant <= '0;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.granted_address = r_out_grant;

endmodule

FILE: src/ffa_extent_cell.sv
// One cell of the sorted free-extent row: holds one extent, shifts with its neighbors.
`timescale 1ns / 1ps

module ffa_extent_cell #(
    parameter int LEN_W        = 11,
    parameter int HEADER_BYTES = 16,
    parameter int INIT_START   = 0,
    parameter int INIT_LEN     = 0,
    parameter bit INIT_VALID   = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffa_pkg::t_ext_ctl   i_ctl,
    input  logic [LEN_W-1:0]    i_blk_start,
    input  logic [LEN_W-1:0]    i_blk_len,
    input  logic                i_prev_fit_any,
    output logic                o_fit_any,
    input  logic                i_prev_le,
    output logic                o_le,
    input  logic [LEN_W-1:0]    i_prev_start,
    input  logic [LEN_W-1:0]    i_prev_len,
    input  logic                i_prev_valid,
    input  logic [LEN_W-1:0]    i_next_start,
    input  logic [LEN_W-1:0]    i_next_len,
    input  logic                i_next_valid,
    output logic [LEN_W-1:0]    o_start,
    output logic [LEN_W-1:0]    o_len,
    output logic                o_valid,
    output logic [LEN_W-1:0]    o_sel_start,
    output logic [LEN_W-1:0]    o_sel_len,
    output logic                o_sel_big
);
    import ffa_pkg::*;

    localparam int CW = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 2;

    logic [LEN_W-1:0] r_start, n_start;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_valid, n_valid;
    logic             r_fit;
    logic             r_big;
    logic [CW-1:0]    len_x;
    logic [CW-1:0]    size_x;
    logic [CW-1:0]    need_x;
    logic             sel;

    assign len_x  = CW'(r_len);
    assign size_x = CW'(i_ctl.size);
    assign need_x = size_x + CW'(HEADER_BYTES);

    // First fit: this cell fits and no cell before it does
    assign sel       = r_fit & ~i_prev_fit_any;
    assign o_fit_any = i_prev_fit_any | r_fit;

    // Insert point: extents at or below the freed start stay put
    assign o_le = r_valid & (r_start <= i_blk_start);

    // Next contents per broadcast update
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_valid = r_valid;
        case (i_ctl.op)
            EXT_SHRINK: begin
                if (sel) begin
                    n_len = LEN_W'(len_x - need_x);
                end
            end
            EXT_REMOVE: begin
                // cells at or after the removed one pull from the right
                if (o_fit_any) begin
                    n_start = i_next_start;
                    n_len   = i_next_len;
                    n_valid = i_next_valid;
                end
            end
            EXT_INSERT: begin
                if (!o_le) begin
                    if (i_prev_le) begin
                        n_start = i_blk_start;
                        n_len   = i_blk_len;
                        n_valid = 1'b1;
                    end else begin
                        n_start = i_prev_start;
                        n_len   = i_prev_len;
                        n_valid = i_prev_valid;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Extent registers and fit flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= LEN_W'(INIT_START);
            r_len   <= LEN_W'(INIT_LEN);
            r_valid <= INIT_VALID;
            r_fit   <= 1'b0;
            r_big   <= 1'b0;
        end else begin
            r_start <= n_start;
            r_len   <= n_len;
            r_valid <= n_valid;
            if (i_ctl.match) begin
                r_fit <= r_valid && (len_x >= size_x);
                r_big <= len_x > need_x;
            end
        end
    end

    assign o_start     = r_start;
    assign o_len       = r_len;
    assign o_valid     = r_valid;
    assign o_sel_start = sel ? r_start : '0;
    assign o_sel_len   = sel ? r_len : '0;
    assign o_sel_big   = sel & r_big;

endmodule

FILE: src/ffa_live_cell.sv
// One cell of the live-block table: holds one allocated block, matched by start.
`timescale 1ns / 1ps

module ffa_live_cell #(
    parameter int LEN_W = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffa_pkg::t_live_ctl i_ctl,
    input  logic [LEN_W-1:0]   i_wr_start,
    input  logic [LEN_W-1:0]   i_wr_len,
    input  logic               i_prev_hit_any,
    output logic               o_hit_any,
    input  logic               i_prev_free_any,
    output logic               o_free_any,
    output logic [LEN_W-1:0]   o_sel_start,
    output logic [LEN_W-1:0]   o_sel_len
);
    import ffa_pkg::*;

    localparam int GW = (LEN_W > ADDR_W) ? LEN_W : ADDR_W;

    logic             r_valid;
    logic             r_hit;
    logic [LEN_W-1:0] r_start;
    logic [LEN_W-1:0] r_len;
    logic             hit_sel;
    logic             free_sel;

    // Priority chains: first matching entry, first empty slot
    assign hit_sel    = r_hit & ~i_prev_hit_any;
    assign o_hit_any  = i_prev_hit_any | r_hit;
    assign free_sel   = ~r_valid & ~i_prev_free_any;
    assign o_free_any = i_prev_free_any | ~r_valid;

    // Valid bit and match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.match) begin
                r_hit <= r_valid && (GW'(r_start) == GW'(i_ctl.addr));
            end
            case (i_ctl.op)
                LIVE_WRITE: begin
                    if (free_sel) begin
                        r_valid <= 1'b1;
                    end
                end
                LIVE_CLEAR: begin
                    if (hit_sel) begin
                        r_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Block payload, written on allocation
    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == LIVE_WRITE) && free_sel) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end
    end

    assign o_sel_start = hit_sel ? r_start : '0;
    assign o_sel_len   = hit_sel ? r_len : '0;

endmodule

FILE: src/ffa_checker.sv
// Port-level checks of the first-fit allocator, bound to the top level.
`timescale 1ns / 1ps

module ffa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input ffa_pkg::t_status          i_rsp_status,
    input logic [ffa_pkg::ADDR_W-1:0] i_rsp_granted
);
    import ffa_pkg::*;

    logic req_xfer;
    assign req_xfer = i_req_valid && i_req_ready;

    // Stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_granted)))
        else $error("response dropped or changed while stalled");

    // A fresh response follows a taken request via match, select, apply
    a_rsp_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(req_xfer, 4))
        else $error("response without a matching request");

    // No second request while one is being worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> (!i_req_ready ##1 !i_req_ready))
        else $error("request taken while busy");

    // Address is zero unless the request succeeded
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_granted == '0))
        else $error("nonzero address on failed request");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_granted (o_rsp.granted_address)
);
